// ----- hdl/ptrq_pkg.sv -----
// ----------------------------------------------------------------------------
// ptrq_pkg
// Shared types and constants for the persistent trie range query block.
// ----------------------------------------------------------------------------
`default_nettype none
package ptrq_pkg;

  localparam int CMD_W   = 3;
  localparam int OPND_W  = 25;
  localparam int POS_W   = 20;
  localparam int ANS_W   = 25;

  // trie geometry and capacities
  localparam int VALUE_BITS   = 25;
  localparam int MAX_ITEMS    = 524288;
  localparam int MAX_VERSIONS = 524288;
  localparam int NODE_POOL    = 16777216;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 3'd0,
    CMD_MAXXOR  = 3'd1,
    CMD_REMOVE  = 3'd2,
    CMD_COUNT   = 3'd3,
    CMD_KTH     = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [OPND_W-1:0] operand_value;
    logic [POS_W-1:0]  range_first;
    logic [POS_W-1:0]  range_last;
  } in_item_t;

  typedef struct packed {
    logic [ANS_W-1:0] answer;
    logic             status;
  } out_item_t;

  // classified work handed from the front end to the back end
  typedef enum logic [2:0] {
    JOB_APPEND,
    JOB_MAXXOR,
    JOB_COUNT,
    JOB_KTH,
    JOB_REMOVE,
    JOB_BAD
  } job_kind_t;

  typedef struct packed {
    job_kind_t         kind;
    logic [OPND_W-1:0] opnd;
    logic [POS_W-1:0]  first;
    logic [POS_W-1:0]  last;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROOT_A,
    ST_ROOT_B,
    ST_ROOT_C,
    ST_APP_RD,
    ST_APP_WR,
    ST_APP_LEAF,
    ST_Q_RD,
    ST_Q_CNT,
    ST_Q_STEP,
    ST_Q_LEAF,
    ST_OUT
  } back_state_t;

endpackage
`default_nettype wire

// ----- hdl/ptrq_if.sv -----
// ----------------------------------------------------------------------------
// ptrq_in_if / ptrq_out_if
// Valid/ready channels carrying one input item and one result item.
// ----------------------------------------------------------------------------
`default_nettype none
interface ptrq_in_if;
  logic                     valid;
  logic                     ready;
  logic [ptrq_pkg::CMD_W-1:0]  cmd;
  logic [ptrq_pkg::OPND_W-1:0] operand_value;
  logic [ptrq_pkg::POS_W-1:0]  range_first;
  logic [ptrq_pkg::POS_W-1:0]  range_last;
  modport source (output valid, cmd, operand_value, range_first, range_last,
                  input ready);
  modport sink (input valid, cmd, operand_value, range_first, range_last,
                output ready);
endinterface

interface ptrq_out_if;
  logic                       valid;
  logic                       ready;
  logic [ptrq_pkg::ANS_W-1:0] answer;
  logic                       status;
  modport source (output valid, answer, status, input ready);
  modport sink (input valid, answer, status, output ready);
endinterface
`default_nettype wire

// ----- hdl/ptrq_front.sv -----
// ----------------------------------------------------------------------------
// ptrq_front
// Accepts items, decodes the command and pushes a job for each known command into a 2-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none
module ptrq_front (
  input  wire logic          clk,
  input  wire logic          rst,
  ptrq_in_if.sink            in_ch,
  output ptrq_pkg::job_t     job,
  output logic               job_valid,
  input  wire logic          job_pop
);
  import ptrq_pkg::*;

  job_t       q [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] fill;
  job_t       dec;
  logic       push;

  always_comb begin
    dec.opnd  = in_ch.operand_value;
    dec.first = in_ch.range_first;
    dec.last  = in_ch.range_last;
    case (in_ch.cmd)
      CMD_APPEND: dec.kind = JOB_APPEND;
      CMD_MAXXOR: dec.kind = JOB_MAXXOR;
      CMD_REMOVE: dec.kind = JOB_REMOVE;
      CMD_COUNT:  dec.kind = JOB_COUNT;
      CMD_KTH:    dec.kind = JOB_KTH;
      default:    dec.kind = JOB_BAD;
    endcase
  end

  assign in_ch.ready = (fill != 2'd2);
  assign push        = in_ch.valid && in_ch.ready && (dec.kind != JOB_BAD);
  assign job_valid   = (fill != 2'd0);
  assign job         = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= dec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (job_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, job_pop};
    end
  end
endmodule
`default_nettype wire

// ----- hdl/ptrq_back.sv -----
// ----------------------------------------------------------------------------
// ptrq_back
// Executes jobs: trie path build for appends, length cut for removes, dual root walk for queries.
// ----------------------------------------------------------------------------
`default_nettype none
module ptrq_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire ptrq_pkg::job_t job,
  input  wire logic           job_valid,
  output logic                job_pop,
  ptrq_out_if.source          out_ch
);
  import ptrq_pkg::*;

  localparam int NW  = $clog2(NODE_POOL);
  localparam int PW  = $clog2(MAX_ITEMS + 1);
  localparam int VW  = $clog2(MAX_VERSIONS + 1);
  localparam int CW  = $clog2(MAX_ITEMS + 1);
  localparam int LW  = $clog2(VALUE_BITS + 1);
  localparam int NODE_REC = 2 * NW + CW;
  localparam logic [LW-1:0] TOP_LEVEL = LW'(VALUE_BITS - 1);

  // node memory {left, right, count}; node 0 is fixed as empty
  logic [NODE_REC-1:0] node_mem [NODE_POOL];
  logic [VW-1:0]       pos_mem  [MAX_ITEMS + 1];
  logic [NW-1:0]       root_mem [MAX_VERSIONS + 1];

  back_state_t state, state_next;

  logic [NW-1:0]  next_free;
  logic [VW-1:0]  ver_total;
  logic [PW-1:0]  cur_len;
  job_t           cur;
  logic [LW-1:0]  level;
  logic [NW-1:0]  lo, hi, cur_node;
  logic [NW-1:0]  lo_left, lo_right, hi_left, hi_right;
  logic [VALUE_BITS-1:0] ans;
  logic [OPND_W-1:0] kk;
  logic [OPND_W-1:0] cnt_acc;
  logic           status;
  logic           out_valid;
  logic [ANS_W-1:0] ans_out;

  // node read ports A (lo / old) and B (hi), registered data
  logic [NW-1:0]       ra_addr, rb_addr;
  logic [NODE_REC-1:0] ra_data, rb_data;
  logic                node_we;
  logic [NW-1:0]       node_waddr;
  logic [NODE_REC-1:0] node_wdata;

  logic [PW-1:0]  p_addr_a, p_addr_b;
  logic [VW-1:0]  p_data_a, p_data_b;
  logic [VW-1:0]  r_addr_a, r_addr_b;
  logic [NW-1:0]  r_data_a, r_data_b;
  logic           pos_we, root_we;

  function automatic logic [NW-1:0] left_of(input logic [NODE_REC-1:0] r);
    left_of = r[NODE_REC-1 -: NW];
  endfunction
  function automatic logic [NW-1:0] right_of(input logic [NODE_REC-1:0] r);
    right_of = r[CW +: NW];
  endfunction
  function automatic logic [CW-1:0] count_of(input logic [NODE_REC-1:0] r);
    count_of = r[CW-1:0];
  endfunction

  logic [VALUE_BITS-1:0] vbits;
  logic                  bitv;
  logic                  full;
  logic                  range_bad;
  logic                  rank_bad;
  logic                  want;
  logic                  go;
  logic [CW-1:0]         diff_w;
  logic [NW-1:0]         ch_lo_go, ch_hi_go;
  logic [NW:0]           free_end;

  assign vbits = cur.opnd[VALUE_BITS-1:0];
  assign bitv  = vbits[TOP_LEVEL - level];

  // node 0 always reads as empty
  always_ff @(posedge clk) begin
    if (node_we) node_mem[node_waddr] <= node_wdata;
    ra_data <= (ra_addr == '0) ? '0 : node_mem[ra_addr];
    rb_data <= (rb_addr == '0) ? '0 : node_mem[rb_addr];
  end

  // position 0 -> version 0 -> root 0, handled by address checks
  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[cur_len + 1'b1] <= ver_total + 1'b1;
    p_data_a <= (p_addr_a == '0) ? '0 : pos_mem[p_addr_a];
    p_data_b <= (p_addr_b == '0) ? '0 : pos_mem[p_addr_b];
  end
  always_ff @(posedge clk) begin
    if (root_we) root_mem[ver_total + 1'b1] <= next_free;
    r_data_a <= (r_addr_a == '0) ? '0 : root_mem[r_addr_a];
    r_data_b <= (r_addr_b == '0) ? '0 : root_mem[r_addr_b];
  end

  assign free_end = {1'b0, next_free} + (NW+1)'(VALUE_BITS + 1);
  assign full = (cur_len >= PW'(MAX_ITEMS)) || (ver_total >= VW'(MAX_VERSIONS)) ||
                (free_end > (NW+1)'(NODE_POOL));
  assign range_bad = (cur.first == '0) || (cur.first > cur.last) ||
                     (cur.last > POS_W'(cur_len));
  assign rank_bad  = (cur.kind == JOB_KTH) &&
                     ((cur.opnd == '0) ||
                      (cur.opnd > OPND_W'(cur.last - cur.first + 1'b1)));

  // ra/rb hold the children on side "want" (maxxor) or left (count/kth)
  assign diff_w = count_of(rb_data) - count_of(ra_data);
  assign want   = ~bitv;

  always_comb begin
    case (cur.kind)
      JOB_MAXXOR: go = (diff_w != '0) ? want : ~want;
      JOB_COUNT:  go = bitv;
      JOB_KTH:    go = (kk > OPND_W'(diff_w));
      default:    go = 1'b0;
    endcase
    ch_lo_go = go ? lo_right : lo_left;
    ch_hi_go = go ? hi_right : hi_left;
  end

  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    ra_addr = lo;  rb_addr = hi;
    node_we = 1'b0; node_waddr = cur_node; node_wdata = '0;
    p_addr_a = PW'(cur.first - 1'b1);
    p_addr_b = PW'(cur.last);
    r_addr_a = p_data_a; r_addr_b = p_data_b;
    pos_we = 1'b0; root_we = 1'b0;
    case (state)
      ST_IDLE: begin
        if (job_valid && !out_valid) begin
          job_pop    = 1'b1;
          state_next = ST_ROOT_A;
        end
      end
      ST_ROOT_A: begin
        case (cur.kind)
          JOB_REMOVE: state_next = ST_IDLE;
          JOB_APPEND: begin
            p_addr_b   = cur_len;
            state_next = full ? ST_IDLE : ST_ROOT_B;
          end
          default: state_next = (range_bad || rank_bad) ? ST_OUT : ST_ROOT_B;
        endcase
      end
      ST_ROOT_B: begin
        // the append's new root and position map are written once, here
        if (cur.kind == JOB_APPEND) begin
          pos_we  = 1'b1;
          root_we = 1'b1;
        end
        state_next = ST_ROOT_C;
      end
      ST_ROOT_C: state_next = (cur.kind == JOB_APPEND) ? ST_APP_RD : ST_Q_RD;
      ST_APP_RD: state_next = ST_APP_WR;
      ST_APP_WR: begin
        node_we    = 1'b1;
        node_wdata = {bitv ? left_of(ra_data) : next_free,
                      bitv ? next_free : right_of(ra_data),
                      count_of(ra_data) + 1'b1};
        ra_addr    = bitv ? right_of(ra_data) : left_of(ra_data);
        state_next = (level == TOP_LEVEL) ? ST_APP_LEAF : ST_APP_WR;
      end
      ST_APP_LEAF: begin
        node_we    = 1'b1;
        node_wdata = {{NW{1'b0}}, {NW{1'b0}}, count_of(ra_data) + 1'b1};
        state_next = ST_IDLE;
      end
      ST_Q_RD: state_next = ST_Q_CNT;
      ST_Q_CNT: begin
        if (cur.kind == JOB_MAXXOR) begin
          ra_addr = want ? right_of(ra_data) : left_of(ra_data);
          rb_addr = want ? right_of(rb_data) : left_of(rb_data);
        end else begin
          ra_addr = left_of(ra_data);
          rb_addr = left_of(rb_data);
        end
        state_next = ST_Q_STEP;
      end
      ST_Q_STEP: begin
        ra_addr = ch_lo_go;
        rb_addr = ch_hi_go;
        state_next = (level == TOP_LEVEL) ? ST_Q_LEAF : ST_Q_RD;
      end
      ST_Q_LEAF: state_next = ST_OUT;
      ST_OUT:    state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      next_free <= NW'(1);
      ver_total <= '0;
      cur_len   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_OUT) out_valid <= 1'b1;
      else if (out_valid && out_ch.ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (job_pop) begin
            cur     <= job;
            level   <= '0;
            ans     <= '0;
            cnt_acc <= '0;
            kk      <= job.opnd;
          end
        end
        ST_ROOT_A: begin
          if (cur.kind == JOB_REMOVE)
            cur_len <= (cur.opnd >= OPND_W'(cur_len)) ? '0 :
                       cur_len - PW'(cur.opnd);
          else if (cur.kind != JOB_APPEND)
            status <= range_bad || rank_bad;
        end
        ST_ROOT_C: begin
          lo <= (cur.kind == JOB_APPEND) ? r_data_b : r_data_a;
          hi <= r_data_b;
          if (cur.kind == JOB_APPEND) begin
            cur_node  <= next_free;
            next_free <= next_free + 1'b1;
            ver_total <= ver_total + 1'b1;
            cur_len   <= cur_len + 1'b1;
          end
        end
        ST_APP_WR: begin
          cur_node  <= next_free;
          next_free <= next_free + 1'b1;
          level     <= level + 1'b1;
        end
        ST_Q_CNT: begin
          lo_left  <= left_of(ra_data);
          lo_right <= right_of(ra_data);
          hi_left  <= left_of(rb_data);
          hi_right <= right_of(rb_data);
        end
        ST_Q_STEP: begin
          lo    <= ch_lo_go;
          hi    <= ch_hi_go;
          level <= level + 1'b1;
          ans   <= {ans[VALUE_BITS-2:0], go};
          if (cur.kind == JOB_COUNT && bitv)
            cnt_acc <= cnt_acc + OPND_W'(diff_w);
          if (cur.kind == JOB_KTH && go)
            kk <= kk - OPND_W'(diff_w);
        end
        ST_Q_LEAF: begin
          if (cur.kind == JOB_COUNT)
            cnt_acc <= cnt_acc + OPND_W'(count_of(rb_data) - count_of(ra_data));
        end
        ST_OUT: ans_out <= (cur.kind == JOB_COUNT) ? ANS_W'(cnt_acc) : ANS_W'(ans);
        default: ;
      endcase
    end
  end

  assign out_ch.valid  = out_valid;
  assign out_ch.answer = ans_out;
  assign out_ch.status = status;
endmodule
`default_nettype wire

// ----- hdl/persistent_trie_range_query.sv -----
// ----------------------------------------------------------------------------
// persistent_trie_range_query
// Stack of values kept as versions of a persistent binary trie, with range
// max-xor, count-at-most and k-th smallest queries.
//
// Channels: in_ch (cmd, operand_value, range_first, range_last) and out_ch
// (answer, status), both valid/ready; an item moves when both are high.
// Appends and removes give no result item; queries give exactly one.
// The front end decodes items into a two-entry job queue so the input keeps
// accepting while the back end walks the trie.
// From the back end taking a job: an append does the root lookup, then one node
// write per level plus the leaf; a query walks the trie level by level, each
// step waiting on the dependent registered reads of the node memory; the job
// queue registers each item in front of the back end.
// A remove or an invalid query skips the trie walk.
// Reset clears lengths and the allocator; node memory needs no clearing.
// While out_ch stalls the back end holds the result and starts no new job;
// the job queue fills and in_ch.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none
module persistent_trie_range_query (
  input  wire logic clk,
  input  wire logic rst,
  ptrq_in_if.sink   in_ch,
  ptrq_out_if.source out_ch
);
  import ptrq_pkg::*;

  job_t job;
  logic job_valid;
  logic job_pop;

  ptrq_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .job(job), .job_valid(job_valid), .job_pop(job_pop)
  );

  ptrq_back u_back (
    .clk(clk), .rst(rst), .job(job), .job_valid(job_valid),
    .job_pop(job_pop), .out_ch(out_ch)
  );
endmodule
`default_nettype wire

// ----- verif/persistent_trie_range_query_checker.sv -----
// ----------------------------------------------------------------------------
// persistent_trie_range_query_checker
// Tracks the value stack from accepted input items, computes each query
// answer by brute force over the live stack, and compares the result items.
// ----------------------------------------------------------------------------
`default_nettype none
module persistent_trie_range_query_checker (
  input  wire logic clk,
  input  wire logic rst,
  ptrq_in_if  in_ch,
  ptrq_out_if out_ch,
  output int        fail_count,
  output int        pending_answers
);
  import ptrq_pkg::*;

  localparam int MAX_LEN = MAX_ITEMS;

  logic [OPND_W-1:0] stack_vals[$];
  out_item_t         answer_queue[$];
  int                versions;

  // brute-force answer over positions first..last of the current stack
  function automatic out_item_t query_answer(input logic [CMD_W-1:0] c,
                                             input logic [OPND_W-1:0] op,
                                             input int first, input int last);
    out_item_t r;
    logic [OPND_W-1:0] best;
    int cnt;
    int rank;
    logic [OPND_W-1:0] sorted[$];
    r.answer = '0;
    r.status = 1'b1;
    best = '0;
    cnt = 0;
    if (first == 0 || first > last || last > stack_vals.size()) return r;
    if (c == CMD_KTH && (op == 0 || op > last - first + 1)) return r;
    for (int i = first - 1; i < last; i++) begin
      if (i == first - 1 || (stack_vals[i] ^ op) > (best ^ op)) best = stack_vals[i];
      if (stack_vals[i] <= op) cnt++;
      sorted = {sorted, stack_vals[i]};
    end
    r.status = 1'b0;
    case (c)
      CMD_MAXXOR: r.answer = best;
      CMD_COUNT:  r.answer = ANS_W'(cnt);
      default: begin
        sorted.sort();
        rank = int'(op);
        r.answer = sorted[rank - 1];
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      stack_vals.delete();
      answer_queue.delete();
      versions = 0;
      fail_count <= 0;
      pending_answers <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.cmd)
          CMD_APPEND:
            if (stack_vals.size() < MAX_LEN && versions < MAX_VERSIONS) begin
              stack_vals = {stack_vals, in_ch.operand_value};
              versions++;
            end
          CMD_REMOVE:
            if (in_ch.operand_value >= stack_vals.size()) stack_vals.delete();
            else repeat (int'(in_ch.operand_value)) void'(stack_vals.pop_back());
          CMD_MAXXOR, CMD_COUNT, CMD_KTH:
            answer_queue = {answer_queue,
                            query_answer(in_ch.cmd, in_ch.operand_value,
                                         int'(in_ch.range_first),
                                         int'(in_ch.range_last))};
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (answer_queue.size() == 0) begin
          $error("result with no expectation: answer %0d status %0d",
                 out_ch.answer, out_ch.status);
          fail_count <= fail_count + 1;
        end else begin
          out_item_t exp_item;
          exp_item = answer_queue.pop_front();
          if (out_ch.answer !== exp_item.answer || out_ch.status !== exp_item.status) begin
            if (out_ch.answer !== exp_item.answer)
              $error("answer: expected %0d actual %0d", exp_item.answer, out_ch.answer);
            if (out_ch.status !== exp_item.status)
              $error("status: expected %0d actual %0d", exp_item.status, out_ch.status);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_answers <= answer_queue.size();
    end
  end

endmodule
`default_nettype wire

// ----- verif/persistent_trie_range_query_tb.sv -----
// ----------------------------------------------------------------------------
// persistent_trie_range_query_tb
// Directed and random append/remove/query traffic with random gaps and a long
// output stall; results checked by persistent_trie_range_query_checker.
// ----------------------------------------------------------------------------
`default_nettype none
module persistent_trie_range_query_tb;
  import ptrq_pkg::*;

  localparam int RANDOM_ITEMS = 1810;
  localparam int IDLE_LIMIT   = 20000;
  localparam int LONG_STALL   = 800;
  localparam int STALL_AFTER  = 300;
  // command codes the block ignores
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending_answers;
  int   stack_len;
  int   items_sent;
  bit   long_stall_done;
  int   idle_cycles;

  ptrq_in_if  in_ch();
  ptrq_out_if out_ch();

  persistent_trie_range_query dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  persistent_trie_range_query_checker checker_i (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending_answers(pending_answers)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // valid stays high into the next item when there is no gap
  task automatic send_item(input logic [CMD_W-1:0] c, input logic [OPND_W-1:0] op,
                           input logic [POS_W-1:0] first, input logic [POS_W-1:0] last);
    int gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.cmd           <= c;
    in_ch.operand_value <= op;
    in_ch.range_first   <= first;
    in_ch.range_last    <= last;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (c == CMD_APPEND) stack_len++;
    else if (c == CMD_REMOVE) stack_len = (op >= stack_len) ? 0 : stack_len - int'(op);
  endtask

  function automatic logic [OPND_W-1:0] rand_value();
    case ($urandom_range(0, 3))
      0: return OPND_W'($urandom_range(0, 15));
      1: return {OPND_W{1'b1}} - OPND_W'($urandom_range(0, 15));
      default: return OPND_W'($urandom());
    endcase
  endfunction

  task automatic random_query();
    logic [CMD_W-1:0] c;
    int first, last;
    logic [OPND_W-1:0] op;
    case ($urandom_range(0, 2))
      0: c = CMD_MAXXOR;
      1: c = CMD_COUNT;
      default: c = CMD_KTH;
    endcase
    if (stack_len == 0 || $urandom_range(0, 9) == 0) begin
      first = $urandom_range(0, stack_len + 2);
      last  = $urandom_range(0, stack_len + 2);
      if ($urandom_range(0, 7) == 0) begin
        first = $urandom() & 20'hfffff;
        last  = $urandom() & 20'hfffff;
      end
    end else begin
      first = $urandom_range(1, stack_len);
      last  = $urandom_range(first, stack_len);
    end
    op = rand_value();
    if (c == CMD_KTH && $urandom_range(0, 7) != 0) op = $urandom_range(1, last - first + 1);
    send_item(c, op, POS_W'(first), POS_W'(last));
  endtask

  // receiver: a random ready gap before each item, plus one long hold-off
  initial begin
    int rx_gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!long_stall_done && items_sent >= STALL_AFTER) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        long_stall_done = 1'b1;
      end
      rx_gap = $urandom_range(0, 5);
      if (rx_gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (rx_gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // watchdog on accepted items and results
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("persistent_trie_range_query_tb NOT OK");
      $finish;
    end
  end

  initial begin
    in_ch.valid         <= 1'b0;
    in_ch.cmd           <= '0;
    in_ch.operand_value <= '0;
    in_ch.range_first   <= '0;
    in_ch.range_last    <= '0;
    stack_len = 0;
    items_sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: empty queries, extremes, each command, special cases
    send_item(CMD_MAXXOR, 0, 1, 1);
    send_item(CMD_COUNT, 0, 0, 0);
    send_item(CMD_REMOVE, 3, 0, 0);
    send_item(CMD_APPEND, '0, 0, 0);
    send_item(CMD_APPEND, {OPND_W{1'b1}}, 0, 0);
    send_item(CMD_APPEND, 25'h0AAAAAA, 0, 0);
    send_item(CMD_APPEND, 25'h1555555, 0, 0);
    send_item(CMD_MAXXOR, '0, 1, 4);
    send_item(CMD_MAXXOR, {OPND_W{1'b1}}, 2, 3);
    send_item(CMD_COUNT, {OPND_W{1'b1}}, 1, 4);
    send_item(CMD_COUNT, 25'h0AAAAAA, 2, 4);
    send_item(CMD_KTH, 1, 1, 4);
    send_item(CMD_KTH, 4, 1, 4);
    send_item(CMD_KTH, 0, 1, 4);
    send_item(CMD_KTH, 5, 1, 4);
    send_item(CMD_COUNT, 1, 3, 2);
    send_item(CMD_COUNT, 1, 1, 5);
    send_item(CMD_COUNT, 1, 20'hfffff, 20'hfffff);
    send_item(CMD_UNUSED_LO, 0, 0, 0);
    send_item(CMD_UNUSED_HI, {OPND_W{1'b1}}, 20'hfffff, 20'hfffff);
    send_item(CMD_REMOVE, 1, 0, 0);
    send_item(CMD_KTH, 3, 1, 3);
    send_item(CMD_REMOVE, {OPND_W{1'b1}}, 0, 0);
    send_item(CMD_MAXXOR, 0, 1, 1);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6:
          send_item(CMD_APPEND, rand_value(), POS_W'($urandom()), POS_W'($urandom()));
        7:
          send_item(CMD_REMOVE, ($urandom_range(0, 15) == 0) ? rand_value() :
                    OPND_W'($urandom_range(0, 4)), POS_W'($urandom()), POS_W'($urandom()));
        8:
          send_item(CMD_UNUSED_LO + CMD_W'($urandom_range(0, 2)), rand_value(),
                    POS_W'($urandom()), POS_W'($urandom()));
        default: random_query();
      endcase
      if (stack_len > 60) send_item(CMD_REMOVE, OPND_W'($urandom_range(20, 50)), 0, 0);
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending_answers == 0 && long_stall_done);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_answers == 0)
      $display("persistent_trie_range_query_tb OK");
    else
      $display("persistent_trie_range_query_tb NOT OK");
    $finish;
  end

endmodule
`default_nettype wire
